// ===== rtl/dequant_batchnorm_requant_unit_assert.svh =====
// Assertion macros shared by the dequantise, batch-norm and requantise unit.
`ifndef DEQUANT_BATCHNORM_REQUANT_UNIT_ASSERT_SVH
`define DEQUANT_BATCHNORM_REQUANT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define DBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dequant_batchnorm_requant_unit: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DBR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dequant_batchnorm_requant_unit: next-cycle check failed");

`else

`define DBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DBR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/dbr_pkg.sv =====
// Package with types and constants of the dequantise, batch-norm and requantise unit.
package dbr_pkg;

    // Configuration register indexes.
    localparam logic [7:0] CFG_DQ_SCALE    = 8'd0;
    localparam logic [7:0] CFG_RQ_SCALE    = 8'd1;
    localparam logic [7:0] CFG_RELU_ENABLE = 8'd2;
    localparam logic [7:0] CFG_ROUND_MODE  = 8'd3;
    localparam logic [7:0] CFG_OUTPUT_MODE = 8'd4;

    // Configuration reset values (scales are 1.0 in Q8.24).
    localparam logic [31:0] DQ_SCALE_RESET = 32'h0100_0000;
    localparam logic [31:0] RQ_SCALE_RESET = 32'h0100_0000;

    // Item opcodes.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Tie rules for the int8 rounding.
    localparam logic [1:0] RND_TIES_EVEN = 2'd0;
    localparam logic [1:0] RND_TIES_ZERO = 2'd1;
    localparam logic [1:0] RND_TIES_AWAY = 2'd2;

    // Output formats.
    localparam logic OUT_FIXED = 1'b0;
    localparam logic OUT_INT8  = 1'b1;

    // Datapath widths: batch-norm magnitude with 40 fraction bits, rounded Q16.16 magnitude.
    localparam int MAG_W = 96;
    localparam int QW    = 72;

    // Saturation limits on the magnitude.
    localparam logic [QW-1:0] LIM_FIX_POS = 72'h00_0000_0000_7FFF_FFFF;
    localparam logic [QW-1:0] LIM_FIX_NEG = 72'h00_0000_0000_8000_0000;
    localparam logic [QW-1:0] LIM_Q8_POS  = 72'd127;
    localparam logic [QW-1:0] LIM_Q8_NEG  = 72'd128;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [31:0] dq_scale;
        logic [31:0] rq_scale;
        logic        relu_enable;
        logic [1:0]  round_mode;
        logic        output_mode;
    } cfg_t;

    // Sample beat leaving the memory read stage.
    typedef struct packed {
        logic [31:0] sample;
        logic [9:0]  channel;
        logic        in_range;
    } smp_beat_t;

    // Batch-norm result in sign-magnitude form.
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic [9:0]       channel;
    } bn_beat_t;

endpackage

// ===== rtl/dbr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dbr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data register holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/dbr_bn.sv =====
// Dequantise and batch-norm datapath: four pipeline stages to a sign-magnitude value.
module dbr_bn (
    input  logic              clk,
    input  logic              rst_n,
    input  dbr_pkg::cfg_t     cfg,
    input  logic              up_valid,
    input  dbr_pkg::smp_beat_t up_beat,
    input  logic [63:0]       coef,
    output logic              take,
    output logic              dn_valid,
    output dbr_pkg::bn_beat_t dn_beat,
    input  logic              dn_take
);
    import dbr_pkg::*;

    logic en2, en3, en4, en5;

    logic        v2_reg, v3_reg, v4_reg, v5_reg;
    logic [9:0]  ch2_reg, ch3_reg, ch4_reg, ch5_reg;
    logic        sgn2_reg, sgn3_reg, sgn4_reg;
    logic        bn2_reg, bn3_reg, bn4_reg;
    logic [31:0] cm2_reg;
    logic [31:0] bm2_reg, bm3_reg;
    logic [63:0] p1_reg;
    logic [63:0] pa_reg, pb_reg;
    logic [95:0] s_reg;
    logic [55:0] b_reg;
    logic [MAG_W-1:0] mag_reg;
    logic        neg_reg;

    logic [31:0] sc_raw, bi_raw, sm, cm, bm;
    logic        sn, cn, bn;
    logic [63:0] p1_next, pa_next, pb_next;
    logic [95:0] s_next;
    logic [96:0] s_minus_b;
    logic [95:0] s_plus_b, b_minus_s;
    logic [MAG_W-1:0] mag_next;
    logic        neg_next;

    // A stage loads when it is empty or its content moves on.
    assign en5  = !v5_reg || dn_take;
    assign en4  = !v4_reg || en5;
    assign en3  = !v3_reg || en4;
    assign en2  = !v2_reg || en3;
    assign take = en2;

    // Stage 2: magnitudes, signs and the dequantise product.
    always_comb
    begin
        sc_raw  = up_beat.in_range ? coef[63:32] : 32'd0;
        bi_raw  = up_beat.in_range ? coef[31:0] : 32'd0;
        sn      = up_beat.sample[31];
        cn      = sc_raw[31];
        bn      = bi_raw[31];
        sm      = sn ? (~up_beat.sample + 32'd1) : up_beat.sample;
        cm      = cn ? (~sc_raw + 32'd1) : sc_raw;
        bm      = bn ? (~bi_raw + 32'd1) : bi_raw;
        p1_next = 64'(sm) * 64'(cfg.dq_scale);
    end

    // Stage 3: two 32 by 32 partial products of the scale multiplication.
    assign pa_next = 64'(p1_reg[31:0]) * 64'(cm2_reg);
    assign pb_next = 64'(p1_reg[63:32]) * 64'(cm2_reg);

    // Stage 4: combine partial products into the 40-fraction-bit magnitude.
    assign s_next = 96'(pa_reg) + {pb_reg, 32'd0};

    // Stage 5: signed add of bias, zero sign clean-up and optional ReLU.
    always_comb
    begin
        s_minus_b = {1'b0, s_reg} - {41'd0, b_reg};
        s_plus_b  = s_reg + {40'd0, b_reg};
        b_minus_s = {40'd0, b_reg} - s_reg;
        if (sgn4_reg == bn4_reg)
        begin
            mag_next = s_plus_b;
            neg_next = sgn4_reg;
        end
        else if (s_minus_b[96])
        begin
            mag_next = b_minus_s;
            neg_next = bn4_reg;
        end
        else
        begin
            mag_next = s_minus_b[95:0];
            neg_next = sgn4_reg;
        end
        if (mag_next == '0)
        begin
            neg_next = 1'b0;
        end
        if (cfg.relu_enable && neg_next)
        begin
            mag_next = '0;
            neg_next = 1'b0;
        end
    end

    // Valid flags of the four stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en2)
            begin
                v2_reg <= up_valid;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Payload registers of the four stages.
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            ch2_reg  <= up_beat.channel;
            sgn2_reg <= sn ^ cn;
            bn2_reg  <= bn;
            cm2_reg  <= cm;
            bm2_reg  <= bm;
            p1_reg   <= p1_next;
        end
        if (en3)
        begin
            ch3_reg  <= ch2_reg;
            sgn3_reg <= sgn2_reg;
            bn3_reg  <= bn2_reg;
            bm3_reg  <= bm2_reg;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
        end
        if (en4)
        begin
            ch4_reg  <= ch3_reg;
            sgn4_reg <= sgn3_reg;
            bn4_reg  <= bn3_reg;
            s_reg    <= s_next;
            b_reg    <= {bm3_reg, 24'd0};
        end
        if (en5)
        begin
            ch5_reg <= ch4_reg;
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
    end

    assign dn_valid        = v5_reg;
    assign dn_beat.mag     = mag_reg;
    assign dn_beat.neg     = neg_reg;
    assign dn_beat.channel = ch5_reg;

endmodule

// ===== rtl/dbr_rq.sv =====
// Rounding, requantise and saturation datapath with the output register.
module dbr_rq (
    input  logic              clk,
    input  logic              rst_n,
    input  dbr_pkg::cfg_t     cfg,
    input  logic              up_valid,
    input  dbr_pkg::bn_beat_t up_beat,
    output logic              take,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       result_value,
    output logic [9:0]        result_channel,
    output logic              clipped
);
    import dbr_pkg::*;

    localparam logic [23:0] HALF24 = 24'h80_0000;
    localparam logic [63:0] HALF64 = 64'h8000_0000_0000_0000;

    // Decide whether to round the magnitude up under the given tie rule.
    function automatic logic round_up(input logic gt, input logic eq, input logic odd,
                                      input logic [1:0] mode);
        logic up;
        if (gt)
        begin
            up = 1'b1;
        end
        else if (!eq)
        begin
            up = 1'b0;
        end
        else
        begin
            case (mode)
                RND_TIES_ZERO: up = 1'b0;
                RND_TIES_AWAY: up = 1'b1;
                default:       up = odd;
            endcase
        end
        return up;
    endfunction

    logic en6, en7, en8, en_out;

    logic          v6_reg, v7_reg, v8_reg, out_valid_reg;
    logic [9:0]    ch6_reg, ch7_reg, ch8_reg;
    logic          neg6_reg, neg7_reg, neg8_reg;
    logic [QW-1:0] qfix6_reg, qfix7_reg, qsel_reg;
    logic [63:0]   pp0_reg, pp1_reg, pp2_reg;
    logic [127:0]  sum_reg;
    logic [31:0]   value_reg;
    logic [9:0]    ch_out_reg;
    logic          clip_reg;

    logic [QW-1:0] qfix_trunc, qfix_next, qsel_next;
    logic          rnd_fix, rnd_int;
    logic [127:0]  sum_next;
    logic [63:0]   qint;
    logic [QW-1:0] limit, mag_sat;
    logic          clip_next;
    logic [31:0]   mag32, value_next;

    // Stages load when empty or when their content moves on.
    assign en_out = !out_valid_reg || !out_stall;
    assign en8    = !v8_reg || en_out;
    assign en7    = !v7_reg || en8;
    assign en6    = !v6_reg || en7;
    assign take   = en6;

    // Stage 6: Q16.16 rounding (ties to even) and the three requantise partial products.
    always_comb
    begin
        qfix_trunc = up_beat.mag[MAG_W-1:24];
        rnd_fix    = round_up(up_beat.mag[23:0] > HALF24, up_beat.mag[23:0] == HALF24,
                              qfix_trunc[0], RND_TIES_EVEN);
        qfix_next  = qfix_trunc + QW'(rnd_fix);
    end

    // Stage 7: sum of the partial products, 64 fraction bits.
    assign sum_next = 128'(pp0_reg) + {32'd0, pp1_reg, 32'd0} + {pp2_reg, 64'd0};

    // Stage 8: integer rounding and choice of the output format.
    always_comb
    begin
        rnd_int   = round_up(sum_reg[63:0] > HALF64, sum_reg[63:0] == HALF64,
                             sum_reg[64], cfg.round_mode);
        qint      = sum_reg[127:64] + 64'(rnd_int);
        qsel_next = (cfg.output_mode == OUT_INT8) ? QW'(qint) : qfix7_reg;
    end

    // Output stage: saturation and conversion back to two's complement.
    always_comb
    begin
        if (cfg.output_mode == OUT_INT8)
        begin
            limit = neg8_reg ? LIM_Q8_NEG : LIM_Q8_POS;
        end
        else
        begin
            limit = neg8_reg ? LIM_FIX_NEG : LIM_FIX_POS;
        end
        clip_next  = qsel_reg > limit;
        mag_sat    = clip_next ? limit : qsel_reg;
        mag32      = mag_sat[31:0];
        value_next = neg8_reg ? (32'd0 - mag32) : mag32;
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en6)
            begin
                v6_reg <= up_valid;
            end
            if (en7)
            begin
                v7_reg <= v6_reg;
            end
            if (en8)
            begin
                v8_reg <= v7_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v8_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            ch6_reg   <= up_beat.channel;
            neg6_reg  <= up_beat.neg;
            qfix6_reg <= qfix_next;
            pp0_reg   <= 64'(up_beat.mag[31:0]) * 64'(cfg.rq_scale);
            pp1_reg   <= 64'(up_beat.mag[63:32]) * 64'(cfg.rq_scale);
            pp2_reg   <= 64'(up_beat.mag[95:64]) * 64'(cfg.rq_scale);
        end
        if (en7)
        begin
            ch7_reg   <= ch6_reg;
            neg7_reg  <= neg6_reg;
            qfix7_reg <= qfix6_reg;
            sum_reg   <= sum_next;
        end
        if (en8)
        begin
            ch8_reg  <= ch7_reg;
            neg8_reg <= neg7_reg;
            qsel_reg <= qsel_next;
        end
        if (en_out)
        begin
            value_reg  <= value_next;
            ch_out_reg <= ch8_reg;
            clip_reg   <= clip_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_value   = value_reg;
    assign result_channel = ch_out_reg;
    assign clipped        = clip_reg;

endmodule

// ===== rtl/dequant_batchnorm_requant_unit.sv =====
// Top level of the dequantise, batch-norm, ReLU and requantise unit.
// Takes one beat per cycle while in_stall is low; a sample passes stage 1, stages 2 to 8
// and the output register, and stalls only back up through full stages.
// Throughput without stalls is one beat per cycle, set by the single coefficient memory
// port pair. Reset empties the pipeline and restores the configuration defaults; the
// coefficient memory is not cleared and must be loaded before a channel is used.
`include "dequant_batchnorm_requant_unit_assert.svh"

module dequant_batchnorm_requant_unit #(
    parameter int CHANNELS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [9:0]  channel,
    input  logic [31:0] sample,
    input  logic [31:0] coef_scale,
    input  logic [31:0] coef_bias,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_value,
    output logic [9:0]  result_channel,
    output logic        clipped,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import dbr_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [16:0] CH_LIMIT = 17'(CHANNELS);

    cfg_t        cfg_reg;
    logic        v1_reg;
    logic [31:0] smp1_reg;
    logic [9:0]  ch1_reg;
    logic        inr1_reg;

    logic           en1, accept, in_range, ram_we;
    logic [AW+9:0]  ch_ext;
    logic [AW-1:0]  addr;
    logic [63:0]    ram_rdata;
    smp_beat_t      smp_beat;
    logic           bn_take, bn_valid, rq_take;
    bn_beat_t       bn_beat;
    logic           int8_out, fix_out, int8_shape, int8_edge, fix_edge;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dq_scale    <= DQ_SCALE_RESET;
            cfg_reg.rq_scale    <= RQ_SCALE_RESET;
            cfg_reg.relu_enable <= 1'b0;
            cfg_reg.round_mode  <= RND_TIES_EVEN;
            cfg_reg.output_mode <= OUT_FIXED;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DQ_SCALE:    cfg_reg.dq_scale    <= cfg_data;
                CFG_RQ_SCALE:    cfg_reg.rq_scale    <= cfg_data;
                CFG_RELU_ENABLE: cfg_reg.relu_enable <= cfg_data[0];
                CFG_ROUND_MODE:  cfg_reg.round_mode  <= cfg_data[1:0];
                CFG_OUTPUT_MODE: cfg_reg.output_mode <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Input handshake and coefficient memory addressing.
    assign en1      = !v1_reg || bn_take;
    assign in_stall = !en1;
    assign accept   = in_valid && en1;
    assign ch_ext   = {{AW{1'b0}}, channel};
    assign addr     = ch_ext[AW-1:0];
    assign in_range = {7'd0, channel} < CH_LIMIT;
    assign ram_we   = accept && (opcode == OP_LOAD) && in_range;

    dbr_ram #(
        .WIDTH (64),
        .DEPTH (CHANNELS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata ({coef_scale, coef_bias}),
        .re    (en1),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    // Stage 1: sample fields wait alongside the memory read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= in_valid && (opcode == OP_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            smp1_reg <= sample;
            ch1_reg  <= channel;
            inr1_reg <= in_range;
        end
    end

    assign smp_beat.sample   = smp1_reg;
    assign smp_beat.channel  = ch1_reg;
    assign smp_beat.in_range = inr1_reg;

    dbr_bn u_bn (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (v1_reg),
        .up_beat  (smp_beat),
        .coef     (ram_rdata),
        .take     (bn_take),
        .dn_valid (bn_valid),
        .dn_beat  (bn_beat),
        .dn_take  (rq_take)
    );

    dbr_rq u_rq (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .up_valid       (bn_valid),
        .up_beat        (bn_beat),
        .take           (rq_take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_value   (result_value),
        .result_channel (result_channel),
        .clipped        (clipped)
    );

    // Output beat classes and value shapes looked at by the checks below.
    assign int8_out   = out_valid && (cfg_reg.output_mode == OUT_INT8);
    assign fix_out    = out_valid && (cfg_reg.output_mode == OUT_FIXED);
    assign int8_shape = (result_value[31:7] == 25'h0) || (result_value[31:7] == 25'h1FF_FFFF);
    assign int8_edge  = (result_value == 32'h0000_007F) || (result_value == 32'hFFFF_FF80);
    assign fix_edge   = (result_value == 32'h7FFF_FFFF) || (result_value == 32'h8000_0000);

    // A held stage-1 sample keeps its coefficients on the memory output.
    `DBR_ASSERT_NXT(a_coef_hold, clk, rst_n, v1_reg && !bn_take, $stable(ram_rdata))
    // Quantised results are always sign-extended int8 values.
    `DBR_ASSERT_IMP(a_int8_range, clk, rst_n, int8_out, int8_shape)
    // A clipped quantised result sits on one of the int8 limits.
    `DBR_ASSERT_IMP(a_int8_clip, clk, rst_n, int8_out && clipped, int8_edge)
    // A clipped fixed-point result sits on one of the 32-bit limits.
    `DBR_ASSERT_IMP(a_fix_clip, clk, rst_n, fix_out && clipped, fix_edge)

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the dequantise, batch-norm, ReLU and requantise unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbr_pkg::*;

    localparam int NUM_PHASES      = 14;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 500000;

    // One input beat as presented to the block.
    typedef struct packed {
        logic        op;
        logic [9:0]  ch;
        logic [31:0] x;
        logic [31:0] cs;
        logic [31:0] cb;
    } bn_item_t;

    // One result beat as expected from the block.
    typedef struct packed {
        logic [31:0] value;
        logic [9:0]  chan;
        logic        clip;
    } bn_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = OP_LOAD;
    logic [9:0]  channel = '0;
    logic [31:0] sample = '0;
    logic [31:0] coef_scale = '0;
    logic [31:0] coef_bias = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] result_value;
    logic [9:0]  result_channel;
    logic        clipped;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = CFG_DQ_SCALE;
    logic [31:0] cfg_data = '0;

    dequant_batchnorm_requant_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .channel        (channel),
        .sample         (sample),
        .coef_scale     (coef_scale),
        .coef_bias      (coef_bias),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_value   (result_value),
        .result_channel (result_channel),
        .clipped        (clipped),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Predictor state: coefficient tables and the register settings in force.
    logic [31:0] scale_mem [0:1023];
    logic [31:0] bias_mem [0:1023];
    logic [31:0] dq_scale = DQ_SCALE_RESET;
    logic [31:0] q_scale = RQ_SCALE_RESET;
    logic        relu_on = 1'b0;
    logic [1:0]  rnd_mode = RND_TIES_EVEN;
    logic        out_mode = OUT_FIXED;

    bn_item_t    items_to_send [$];
    bn_result_t  bn_results_due [$];
    logic [9:0]  ready_list [$];
    bit          ch_ready [0:1023];

    int          in_gap_max = 14;
    int          out_gap_max = 14;
    int          in_gap = 0;
    int          out_wait = 0;
    int          stall_draw;
    int          hold_req = 0;
    int          hold_ack = 0;
    int          hold_left = 0;
    int          errors = 0;
    int unsigned cycle_count = 0;
    bn_item_t    next_beat;
    bn_result_t  due;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the result of one accepted beat; loads only update the tables.
    function automatic void compute_bn_result(input logic op, input logic [9:0] ch,
            input logic [31:0] x, input logic [31:0] cs, input logic [31:0] cb);
        logic [127:0] xm, cm, bm, prod_mag, bias_mag, bn_mag;
        logic [159:0] q_prod;
        logic [71:0]  q, lim, mag;
        logic         vneg, bneg, up, clip;
        bn_result_t   r;
        if (op == OP_LOAD)
        begin
            scale_mem[ch] = cs;
            bias_mem[ch] = cb;
            return;
        end
        xm = x[31] ? {96'd0, -x} : {96'd0, x};
        cm = scale_mem[ch][31] ? {96'd0, -scale_mem[ch]} : {96'd0, scale_mem[ch]};
        bm = bias_mem[ch][31] ? {96'd0, -bias_mem[ch]} : {96'd0, bias_mem[ch]};
        bneg = bias_mem[ch][31];
        vneg = x[31] ^ scale_mem[ch][31];

        // Exact sign-magnitude sum with 40 fraction bits.
        prod_mag = xm * dq_scale * cm;
        bias_mag = bm << 24;
        if (vneg == bneg)
            bn_mag = prod_mag + bias_mag;
        else if (prod_mag < bias_mag)
        begin
            bn_mag = bias_mag - prod_mag;
            vneg = bneg;
        end
        else
            bn_mag = prod_mag - bias_mag;
        if (bn_mag == '0)
            vneg = 1'b0;
        if (relu_on && vneg)
        begin
            bn_mag = '0;
            vneg = 1'b0;
        end

        // Rounding to Q16.16 (ties even) or to an integer after requantising.
        if (out_mode == OUT_FIXED)
        begin
            q = bn_mag[95:24];
            if (bn_mag[23:0] != 24'h80_0000)
                up = bn_mag[23];
            else
                up = q[0];
            lim = vneg ? LIM_FIX_NEG : LIM_FIX_POS;
        end
        else
        begin
            q_prod = bn_mag * q_scale;
            q = {8'd0, q_prod[127:64]};
            if (q_prod[63:0] != 64'h8000_0000_0000_0000)
                up = q_prod[63];
            else if (rnd_mode == RND_TIES_ZERO)
                up = 1'b0;
            else if (rnd_mode == RND_TIES_AWAY)
                up = 1'b1;
            else
                up = q[0];
            lim = vneg ? LIM_Q8_NEG : LIM_Q8_POS;
        end
        q = q + up;
        clip = q > lim;
        mag = clip ? lim : q;
        r.value = vneg ? -mag[31:0] : mag[31:0];
        r.chan = ch;
        r.clip = clip;
        bn_results_due.push_back(r);
    endfunction

    function automatic void report_bad(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    // Stimulus words: full random, extremes, and values of random magnitude.
    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        case ($urandom_range(0, 7))
            0, 1: w = $urandom();
            2:
            begin
                case ($urandom_range(0, 5))
                    0: w = 32'h7FFF_FFFF;
                    1: w = 32'h8000_0000;
                    2: w = 32'h0;
                    3: w = 32'h1;
                    4: w = 32'h0001_0000;
                    default: w = 32'hFFFF_FFFF;
                endcase
            end
            default:
            begin
                w = $urandom() >> $urandom_range(8, 31);
                if ($urandom_range(0, 1) == 1)
                    w = -w;
            end
        endcase
        return w;
    endfunction

    function automatic void queue_load(input logic [9:0] ch, input logic [31:0] cs,
            input logic [31:0] cb);
        items_to_send.push_back({OP_LOAD, ch, $urandom(), cs, cb});
        if (!ch_ready[ch])
        begin
            ch_ready[ch] = 1'b1;
            ready_list.push_back(ch);
        end
    endfunction

    function automatic void queue_sample(input logic [9:0] ch, input logic [31:0] x);
        items_to_send.push_back({OP_SAMPLE, ch, x, $urandom(), $urandom()});
    endfunction

    // Register write through the configuration channel; the predictor follows it.
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DQ_SCALE:    dq_scale = data;
            CFG_RQ_SCALE:    q_scale = data;
            CFG_RELU_ENABLE: relu_on = data[0];
            CFG_ROUND_MODE:  rnd_mode = data[1:0];
            CFG_OUTPUT_MODE: out_mode = data[0];
            default: ;
        endcase
    endtask

    // Waits until every queued beat is sent and every result has come back.
    task automatic wait_drained();
        while (items_to_send.size() != 0 || in_valid || bn_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Input driver: presents queued beats, with a random gap after each one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                compute_bn_result(opcode, channel, sample, coef_scale, coef_bias);
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap <= in_gap - 1;
                end
                else if (items_to_send.size() > 0)
                begin
                    next_beat = items_to_send.pop_front();
                    in_valid <= 1'b1;
                    opcode <= next_beat.op;
                    channel <= next_beat.ch;
                    sample <= next_beat.x;
                    coef_scale <= next_beat.cs;
                    coef_bias <= next_beat.cb;
                    in_gap <= $urandom_range(0, in_gap_max);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long output hold-off, counted here so that the sender keeps going.
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Output monitor: checks each result beat and draws the stall after it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_wait <= 0;
        end
        else
        begin
            stall_draw = out_wait;
            if (out_valid && !out_stall)
            begin
                if (bn_results_due.size() == 0)
                    report_bad($sformatf("unexpected result: value %h chan %0d clip %b",
                        result_value, result_channel, clipped));
                else
                begin
                    due = bn_results_due.pop_front();
                    if (due.value !== result_value || due.chan !== result_channel ||
                            due.clip !== clipped)
                        report_bad($sformatf(
                            "result mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                            due.value, due.chan, due.clip,
                            result_value, result_channel, clipped));
                end
                stall_draw = $urandom_range(0, out_gap_max);
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                out_wait <= stall_draw;
            end
            else if (stall_draw > 0)
            begin
                out_stall <= 1'b1;
                out_wait <= stall_draw - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus sequence: directed checks, then one random phase per setting.
    initial
    begin
        int p;
        int i;
        logic [31:0] dq;
        logic [31:0] qs;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats under the reset configuration.
        queue_load(10'd0, 32'h0001_0000, 32'h0);
        queue_load(10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_load(10'd512, 32'h8000_0000, 32'h8000_0000);
        queue_load(10'd1, 32'h0001_0000, 32'hFFFF_0000);
        queue_load(10'd2, 32'h0000_0001, 32'h0);
        queue_load(10'd10, 32'h0, 32'h0002_8000);
        queue_load(10'd11, 32'h0, 32'hFFFD_8000);
        queue_load(10'd12, 32'h0, 32'h0001_8000);
        queue_load(10'd13, 32'h0, 32'h7FFF_8000);
        queue_sample(10'd0, 32'h0);
        queue_sample(10'd0, 32'h1);
        queue_sample(10'd0, 32'hFFFF_FFFF);
        queue_sample(10'd0, 32'd100);
        queue_sample(10'd0, 32'h7FFF_FFFF);
        queue_sample(10'd0, 32'h8000_0000);
        queue_sample(10'd1023, 32'h7FFF_FFFF);
        queue_sample(10'd512, 32'h8000_0000);
        queue_sample(10'd512, 32'h7FFF_FFFF);
        // A result of exactly zero from a negative path comes out as plain zero.
        queue_sample(10'd1, 32'h1);
        queue_sample(10'd1, 32'h2);
        queue_sample(10'd13, 32'h5);
        wait_drained();

        // Half-LSB products for the ties-to-even rounding of the Q16.16 result.
        write_reg(CFG_DQ_SCALE, 32'h0080_0000);
        @(negedge clk);
        queue_sample(10'd2, 32'd1);
        queue_sample(10'd2, 32'd3);
        queue_sample(10'd2, 32'd5);
        queue_sample(10'd2, 32'hFFFF_FFFF);
        queue_sample(10'd2, 32'hFFFF_FFFD);
        wait_drained();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p % 4)
                0: dq = DQ_SCALE_RESET;
                1: dq = $urandom();
                2: dq = (p < 7) ? 32'hFFFF_FFFF : 32'h0;
                default: dq = $urandom_range(0, 32'h0200_0000);
            endcase
            // Unit quant scale in the early int8 phases makes the half-way channels tie.
            if (p == 9)
                qs = 32'hFFFF_FFFF;
            else if (p == 11)
                qs = 32'h0;
            else if (p < 9 && p % 2 == 1)
                qs = RQ_SCALE_RESET;
            else
                qs = $urandom_range(0, 32'h0800_0000);
            write_reg(CFG_DQ_SCALE, dq);
            write_reg(CFG_RQ_SCALE, qs);
            write_reg(CFG_RELU_ENABLE, {31'd0, ((p / 3) % 2 == 1)});
            write_reg(CFG_ROUND_MODE, 32'((p / 2) % 4));
            write_reg(CFG_OUTPUT_MODE, {31'd0, (p % 2 == 1)});
            in_gap_max = (p % 3 == 2 || p == 4) ? 0 : 14;
            out_gap_max = (p % 4 == 1) ? 0 : 14;
            @(negedge clk);

            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if ($urandom_range(0, 9) < 2)
                    queue_load(10'($urandom_range(16, 1023)), rand_word(), rand_word());
                else if ($urandom_range(0, 7) == 0)
                    queue_sample(10'($urandom_range(10, 13)), rand_word());
                else
                    queue_sample(ready_list[$urandom_range(0, ready_list.size() - 1)],
                        rand_word());
            end
            // Back-pressure: hold the output off long enough to fill the pipeline.
            if (p == 4)
                hold_req++;
            wait_drained();
        end

        if (bn_results_due.size() != 0)
            report_bad($sformatf("%0d results never arrived", bn_results_due.size()));
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
